FILE: hdl/smf_pkg.sv
// ---------------------------------------------------------------------------
// smf_pkg
// Shared types, constants and helpers for the track event parser.
// ---------------------------------------------------------------------------
package smf_pkg;

	localparam int unsigned MAX_NUMBER_BYTES_DEF = 4;
	localparam int unsigned NUM_W   = 28;
	localparam int unsigned NBYTE_W = 3;
	localparam int unsigned TICK_W  = 32;
	localparam int unsigned TRACK_W = 16;

	localparam logic [7:0] DATA_MASK    = 8'h7F;
	localparam logic [7:0] STATUS_MIN   = 8'h80;
	localparam logic [7:0] SYSEX_START  = 8'hF0;
	localparam logic [7:0] META_STATUS  = 8'hFF;
	localparam logic [7:0] SYSEX_END    = 8'hF7;
	localparam logic [7:0] END_OF_TRACK = 8'h2F;
	localparam logic [3:0] NIBBLE_MASK  = 4'hF;
	localparam logic [3:0] HI_PROGRAM   = 4'hC;
	localparam logic [3:0] HI_PRESSURE  = 4'hD;

	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_BEGIN = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_DELTA,
		PH_STATUS,
		PH_P1,
		PH_P2,
		PH_MTYPE,
		PH_MLEN,
		PH_SLEN,
		PH_DATA,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		KIND_CHANNEL,
		KIND_META,
		KIND_SYSEX,
		KIND_PAYLOAD,
		KIND_END_TRACK,
		KIND_END_DATA,
		KIND_TRUNCATED,
		KIND_NO_RUNNING
	} kind_t;

	typedef struct packed {
		logic [15:0] track_id;
		logic        sysex_continues;
		logic        payload_last;
		logic [7:0]  payload_value;
		logic [27:0] payload_length;
		logic [7:0]  meta_type;
		logic [7:0]  param_two;
		logic [7:0]  param_one;
		logic [3:0]  channel;
		logic [7:0]  status_code;
		logic [31:0] abs_tick;
		kind_t       kind;
	} res_t;

	function automatic phase_t enter_phase(input logic [7:0] status);
		phase_t ph;
		if (status < SYSEX_START) begin
			ph = PH_P1;
		end else if (status == META_STATUS) begin
			ph = PH_MTYPE;
		end else begin
			ph = PH_SLEN;
		end
		return ph;
	endfunction

	function automatic logic is_sysex(input logic [7:0] status);
		return (status >= SYSEX_START) && (status != META_STATUS);
	endfunction

	function automatic res_t make_res(
		input kind_t       kind,
		input logic [31:0] tick,
		input logic [7:0]  status,
		input logic [7:0]  meta,
		input logic [27:0] len,
		input logic [7:0]  p1,
		input logic [7:0]  p2,
		input logic [7:0]  val,
		input logic        last,
		input logic        cont,
		input logic [15:0] track
	);
		res_t r;
		r.kind            = kind;
		r.abs_tick        = tick;
		r.status_code     = status;
		r.channel         = (kind == KIND_CHANNEL) ? (status[3:0] & NIBBLE_MASK) : 4'h0;
		r.param_one       = p1;
		r.param_two       = p2;
		r.meta_type       = ((status == META_STATUS) && ((kind == KIND_META) ||
			(kind == KIND_PAYLOAD) || (kind == KIND_END_TRACK))) ? meta : 8'h00;
		r.payload_length  = ((kind == KIND_META) || (kind == KIND_SYSEX) ||
			(kind == KIND_PAYLOAD)) ? len : 28'h0;
		r.payload_value   = val;
		r.payload_last    = last;
		r.sysex_continues = cont;
		r.track_id        = track;
		return r;
	endfunction

endpackage

FILE: hdl/smf_parse.sv
// ---------------------------------------------------------------------------
// smf_parse
// Per-byte phase machine: delta time, running status, event bodies, and up
// to two results per byte (an event result and a terminating result).
// ---------------------------------------------------------------------------
module smf_parse #(
	parameter int unsigned MAX_NUMBER_BYTES = smf_pkg::MAX_NUMBER_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          op,
	input  logic [7:0]    data_byte,
	input  logic          end_of_data,
	input  logic [15:0]   track_number,
	output logic          r0_valid,
	output smf_pkg::res_t r0,
	output logic          r1_valid,
	output smf_pkg::res_t r1
);

	smf_pkg::phase_t phase_q, n_phase;
	logic [27:0] accum_q, n_accum;
	logic [2:0]  nbytes_q, n_nbytes;
	logic [31:0] tick_q, n_tick;
	logic [7:0]  prior_q, n_prior;
	logic        prior_v_q, n_prior_v;
	logic [7:0]  cur_q, n_cur;
	logic [7:0]  first_q, n_first;
	logic [7:0]  meta_q, n_meta;
	logic [27:0] left_q, n_left;
	logic [15:0] track_q, n_track;

	logic          e0_v, e1_v;
	smf_pkg::kind_t e0_kind, e1_kind;
	logic [7:0]    ev_status;
	logic [27:0]   e0_len;
	logic [7:0]    e0_p1, e0_p2, e0_val;
	logic          e0_last, e0_cont;

	always_comb begin : next_state
		logic [27:0] base_acc;
		logic [2:0]  base_nb;
		logic [27:0] acc_add;
		logic [2:0]  nb_add;
		logic        num_done;
		logic [27:0] left_dec;
		smf_pkg::phase_t body_ph;
		logic        run_body;
		logic        in_delta;
		logic        halt;
		logic        done;

		n_phase   = phase_q;
		n_accum   = accum_q;
		n_nbytes  = nbytes_q;
		n_tick    = tick_q;
		n_prior   = prior_q;
		n_prior_v = prior_v_q;
		n_cur     = cur_q;
		n_first   = first_q;
		n_meta    = meta_q;
		n_left    = left_q;
		n_track   = track_q;

		e0_v      = 1'b0;
		e0_kind   = smf_pkg::KIND_CHANNEL;
		e0_len    = '0;
		e0_p1     = '0;
		e0_p2     = '0;
		e0_val    = '0;
		e0_last   = 1'b0;
		e0_cont   = 1'b0;
		e1_v      = 1'b0;
		e1_kind   = smf_pkg::KIND_END_DATA;
		ev_status = cur_q;

		base_acc = accum_q;
		base_nb  = nbytes_q;
		body_ph  = phase_q;
		run_body = 1'b0;
		in_delta = 1'b0;
		halt     = 1'b1;
		done     = 1'b0;
		left_dec = left_q - 28'd1;

		if (step && (op == smf_pkg::OP_DATA)) begin
			halt = 1'b0;
			case (phase_q)
				smf_pkg::PH_IDLE, smf_pkg::PH_DONE: begin
					halt = 1'b1;
				end
				smf_pkg::PH_DELTA: begin
					in_delta = 1'b1;
				end
				smf_pkg::PH_STATUS: begin
					if (data_byte >= smf_pkg::STATUS_MIN) begin
						n_cur     = data_byte;
						n_prior   = data_byte;
						n_prior_v = 1'b1;
						ev_status = data_byte;
						n_phase   = smf_pkg::enter_phase(data_byte);
						if (smf_pkg::is_sysex(data_byte)) begin
							n_accum  = '0;
							n_nbytes = '0;
						end
					end else if (!prior_v_q) begin
						e0_v    = 1'b1;
						e0_kind = smf_pkg::KIND_NO_RUNNING;
						n_phase = smf_pkg::PH_DONE;
						halt    = 1'b1;
					end else begin
						n_cur     = prior_q;
						ev_status = prior_q;
						body_ph   = smf_pkg::enter_phase(prior_q);
						run_body  = 1'b1;
						if (smf_pkg::is_sysex(prior_q)) begin
							base_acc = '0;
							base_nb  = '0;
						end
					end
				end
				default: begin
					run_body = 1'b1;
				end
			endcase
		end

		acc_add  = {base_acc[20:0], data_byte[6:0] & smf_pkg::DATA_MASK[6:0]};
		nb_add   = base_nb + 3'd1;
		num_done = !data_byte[7] || (nb_add >= 3'(MAX_NUMBER_BYTES));

		if (in_delta) begin
			n_accum  = acc_add;
			n_nbytes = nb_add;
			if (num_done) begin
				n_tick  = tick_q + {4'h0, acc_add};
				n_phase = smf_pkg::PH_STATUS;
			end
		end

		if (run_body) begin
			n_phase = body_ph;
			case (body_ph)
				smf_pkg::PH_P1: begin
					n_first = data_byte;
					if ((ev_status[7:4] == smf_pkg::HI_PROGRAM) ||
						(ev_status[7:4] == smf_pkg::HI_PRESSURE)) begin
						e0_v  = 1'b1;
						e0_p1 = data_byte;
						done  = 1'b1;
					end else begin
						n_phase = smf_pkg::PH_P2;
					end
				end
				smf_pkg::PH_P2: begin
					e0_v  = 1'b1;
					e0_p1 = first_q;
					e0_p2 = data_byte;
					done  = 1'b1;
				end
				smf_pkg::PH_MTYPE: begin
					n_meta   = data_byte;
					n_accum  = '0;
					n_nbytes = '0;
					n_phase  = smf_pkg::PH_MLEN;
				end
				smf_pkg::PH_MLEN, smf_pkg::PH_SLEN: begin
					n_accum  = acc_add;
					n_nbytes = nb_add;
					if (num_done) begin
						n_left  = acc_add;
						e0_v    = 1'b1;
						e0_kind = (body_ph == smf_pkg::PH_MLEN) ?
							smf_pkg::KIND_META : smf_pkg::KIND_SYSEX;
						e0_len  = acc_add;
						if (acc_add == '0) begin
							done = 1'b1;
						end else begin
							n_phase = smf_pkg::PH_DATA;
						end
					end
				end
				smf_pkg::PH_DATA: begin
					n_left  = left_dec;
					e0_v    = 1'b1;
					e0_kind = smf_pkg::KIND_PAYLOAD;
					e0_len  = accum_q;
					e0_val  = data_byte;
					e0_last = (left_dec == '0);
					e0_cont = (left_dec == '0) && (ev_status == smf_pkg::SYSEX_START) &&
						(data_byte != smf_pkg::SYSEX_END);
					done    = (left_dec == '0);
				end
				default: begin
				end
			endcase
		end

		if (!halt) begin
			if (done) begin
				if ((ev_status == smf_pkg::META_STATUS) && (meta_q == smf_pkg::END_OF_TRACK)) begin
					e1_v    = 1'b1;
					e1_kind = smf_pkg::KIND_END_TRACK;
					n_phase = smf_pkg::PH_DONE;
				end else if (end_of_data) begin
					e1_v    = 1'b1;
					e1_kind = smf_pkg::KIND_END_DATA;
					n_phase = smf_pkg::PH_DONE;
				end else begin
					n_cur    = '0;
					n_accum  = '0;
					n_nbytes = '0;
					n_phase  = smf_pkg::PH_DELTA;
				end
			end else if (end_of_data) begin
				e1_v    = 1'b1;
				e1_kind = smf_pkg::KIND_TRUNCATED;
				n_phase = smf_pkg::PH_DONE;
			end
		end

		if (step && (op == smf_pkg::OP_BEGIN)) begin
			n_track   = track_number;
			n_tick    = '0;
			n_prior   = '0;
			n_prior_v = 1'b0;
			n_cur     = '0;
			n_first   = '0;
			n_meta    = '0;
			n_left    = '0;
			n_accum   = '0;
			n_nbytes  = '0;
			n_phase   = smf_pkg::PH_DELTA;
		end
	end

	always_comb begin : outputs
		r0_valid = e0_v;
		r1_valid = e1_v;
		r0 = smf_pkg::make_res(e0_kind, n_tick, ev_status, meta_q, e0_len, e0_p1, e0_p2,
			e0_val, e0_last, e0_cont, track_q);
		r1 = smf_pkg::make_res(e1_kind, n_tick, ev_status, meta_q, 28'h0, 8'h00, 8'h00,
			8'h00, 1'b0, 1'b0, track_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= smf_pkg::PH_IDLE;
			accum_q   <= '0;
			nbytes_q  <= '0;
			tick_q    <= '0;
			prior_q   <= '0;
			prior_v_q <= 1'b0;
			cur_q     <= '0;
			first_q   <= '0;
			meta_q    <= '0;
			left_q    <= '0;
			track_q   <= '0;
		end else begin
			phase_q   <= n_phase;
			accum_q   <= n_accum;
			nbytes_q  <= n_nbytes;
			tick_q    <= n_tick;
			prior_q   <= n_prior;
			prior_v_q <= n_prior_v;
			cur_q     <= n_cur;
			first_q   <= n_first;
			meta_q    <= n_meta;
			left_q    <= n_left;
			track_q   <= n_track;
		end
	end

endmodule

FILE: hdl/smf_out_stage.sv
// ---------------------------------------------------------------------------
// smf_out_stage
// Result register plus one pending-result register, so a byte that yields
// two results is taken in a single load.
// ---------------------------------------------------------------------------
module smf_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic          r0_valid,
	input  smf_pkg::res_t r0,
	input  logic          r1_valid,
	input  smf_pkg::res_t r1,
	input  logic          pop_ready,
	output logic          can_take,
	output logic          out_valid,
	output smf_pkg::res_t out_res,
	output logic          tail_valid,
	output smf_pkg::res_t tail_res
);

	logic          o_v_q, t_v_q;
	smf_pkg::res_t o_q, t_q;
	logic          pop;
	logic          load;

	assign pop      = o_v_q && pop_ready;
	assign can_take = !t_v_q && (!o_v_q || pop_ready);
	assign load     = push && can_take && (r0_valid || r1_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
			t_v_q <= 1'b0;
		end else if (t_v_q && pop) begin
			t_v_q <= 1'b0;
		end else if (load) begin
			o_v_q <= 1'b1;
			t_v_q <= r0_valid && r1_valid;
		end else if (pop) begin
			o_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (t_v_q && pop) begin
			o_q <= t_q;
		end else if (load) begin
			o_q <= r0_valid ? r0 : r1;
			t_q <= r1;
		end
	end

	assign out_valid  = o_v_q;
	assign out_res    = o_q;
	assign tail_valid = t_v_q;
	assign tail_res   = t_q;

endmodule

FILE: hdl/smf_track_event_parser_top.sv
// path: input register, then phase machine, then result register
// throughput: one byte per cycle unless m_tready or a two-result byte stalls input
// rate is set by the combinational phase machine between input and result registers
// reset: arst_n asynchronous, clears parse state to idle (waits for a begin transaction)
// ---------------------------------------------------------------------------
// smf_track_event_parser_top
// Standard MIDI file track event parser, one track byte per transaction.
// ---------------------------------------------------------------------------
module smf_track_event_parser_top #(
	parameter int unsigned MAX_NUMBER_BYTES = smf_pkg::MAX_NUMBER_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [23:0]  s_tdata,  // data_byte, track_number
	input  logic         s_tuser,  // op
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata,  // abs_tick, status_code, channel, param_one, param_two,
	                               // meta_type, payload_length, payload_value, track_id
	output logic [3:0]   m_tuser,  // kind, sysex_continues
	output logic         m_tlast
);

	logic        v_s1;
	logic        op_s1;
	logic [7:0]  byte_s1;
	logic        eod_s1;
	logic [15:0] track_s1;

	logic          step;
	logic          can_take;
	logic          r0_valid, r1_valid;
	smf_pkg::res_t r0, r1;
	logic          out_valid, tail_valid;
	smf_pkg::res_t out_res, tail_res;

	assign step     = v_s1 && can_take;
	assign s_tready = !v_s1 || can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1    <= s_tuser;
			byte_s1  <= s_tdata[7:0];
			eod_s1   <= s_tlast;
			track_s1 <= s_tdata[23:8];
		end
	end

	smf_parse #(
		.MAX_NUMBER_BYTES(MAX_NUMBER_BYTES)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.op          (op_s1),
		.data_byte   (byte_s1),
		.end_of_data (eod_s1),
		.track_number(track_s1),
		.r0_valid    (r0_valid),
		.r0          (r0),
		.r1_valid    (r1_valid),
		.r1          (r1)
	);

	smf_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.r0_valid  (r0_valid),
		.r0        (r0),
		.r1_valid  (r1_valid),
		.r1        (r1),
		.pop_ready (m_tready),
		.can_take  (can_take),
		.out_valid (out_valid),
		.out_res   (out_res),
		.tail_valid(tail_valid),
		.tail_res  (tail_res)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = {out_res.track_id, out_res.payload_value, out_res.payload_length,
		out_res.meta_type, out_res.param_two, out_res.param_one, out_res.channel,
		out_res.status_code, out_res.abs_tick};
	assign m_tuser  = {out_res.sysex_continues, out_res.kind};
	assign m_tlast  = out_res.payload_last;

`ifndef SYNTHESIS
	a_tail_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		tail_valid |-> out_valid)
		else $error("pending result without a current result");

	a_tail_terminal: assert property (@(posedge clk) disable iff (!arst_n)
		tail_valid |-> ((tail_res.kind == smf_pkg::KIND_END_TRACK) ||
			(tail_res.kind == smf_pkg::KIND_END_DATA) ||
			(tail_res.kind == smf_pkg::KIND_TRUNCATED)))
		else $error("pending result is not a terminating kind");

	a_no_step_on_tail: assert property (@(posedge clk) disable iff (!arst_n)
		tail_valid |-> !step)
		else $error("byte parsed while a pending result is held");
`endif

endmodule

FILE: tb/sv/smf_track_event_parser_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smf_track_event_parser_top_test
// Drives track chunk bytes into the event parser and checks every result
// transaction against a cycle-free model of the parse kept in the bench.
// Directed tracks cover the corner cases; random well-formed tracks with
// running status, long delta times, truncation and noise follow, with random
// gaps on both sides and one stretch at full rate.
// ---------------------------------------------------------------------------
module smf_track_event_parser_top_test;

	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 16;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [23:0]  s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [119:0] m_tdata;
	logic [3:0]   m_tuser;
	logic         m_tlast;

	smf_track_event_parser_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	smf_pkg::res_t expected_events[$];
	logic [7:0]  track_q[$];
	int          errors = 0;
	int          items_sent = 0;
	int          idle_cycles = 0;
	bit          no_gaps = 1'b0;

	// parser model state
	smf_pkg::phase_t pstate = smf_pkg::PH_IDLE;
	logic [27:0] vlq_acc = '0;
	logic [2:0]  vlq_count = '0;
	logic [31:0] tick_sum = '0;
	logic [7:0]  last_status = '0;
	logic        last_status_ok = 1'b0;
	logic [7:0]  event_status = '0;
	logic [7:0]  held_param = '0;
	logic [7:0]  held_meta = '0;
	logic [27:0] payload_left = '0;
	logic [15:0] track_idx = '0;

	// track generator state
	logic [7:0]  gen_status = '0;
	bit          gen_has = 1'b0;

	function automatic void add_byte(logic [7:0] b);
		track_q.insert(track_q.size(), b);
	endfunction

	function automatic void emit_result(smf_pkg::kind_t k, logic [7:0] p1, logic [7:0] p2,
		logic [7:0] val, logic last, logic cont);
		smf_pkg::res_t r;
		r.kind            = k;
		r.abs_tick        = tick_sum;
		r.status_code     = event_status;
		r.channel         = (k == smf_pkg::KIND_CHANNEL) ? event_status[3:0] : 4'h0;
		r.param_one       = p1;
		r.param_two       = p2;
		r.meta_type       = (event_status == smf_pkg::META_STATUS &&
			(k == smf_pkg::KIND_META || k == smf_pkg::KIND_PAYLOAD ||
			k == smf_pkg::KIND_END_TRACK)) ? held_meta : 8'h00;
		r.payload_length  = (k == smf_pkg::KIND_META || k == smf_pkg::KIND_SYSEX ||
			k == smf_pkg::KIND_PAYLOAD) ? vlq_acc : 28'h0;
		r.payload_value   = val;
		r.payload_last    = last;
		r.sysex_continues = cont;
		r.track_id        = track_idx;
		expected_events.insert(expected_events.size(), r);
	endfunction

	function automatic bit vlq_push(logic [7:0] b);
		vlq_acc   = {vlq_acc[20:0], b[6:0]};
		vlq_count = vlq_count + 3'd1;
		return !b[7] || (vlq_count >= smf_pkg::MAX_NUMBER_BYTES_DEF);
	endfunction

	function automatic void open_event();
		if (event_status < smf_pkg::SYSEX_START) begin
			pstate = smf_pkg::PH_P1;
		end else if (event_status == smf_pkg::META_STATUS) begin
			pstate = smf_pkg::PH_MTYPE;
		end else begin
			vlq_acc   = '0;
			vlq_count = '0;
			pstate    = smf_pkg::PH_SLEN;
		end
	endfunction

	function automatic bit parse_body(logic [7:0] b);
		logic last;
		case (pstate)
			smf_pkg::PH_P1: begin
				held_param = b;
				if (event_status[7:4] == smf_pkg::HI_PROGRAM ||
					event_status[7:4] == smf_pkg::HI_PRESSURE) begin
					emit_result(smf_pkg::KIND_CHANNEL, b, 8'h00, 8'h00, 1'b0, 1'b0);
					return 1'b1;
				end
				pstate = smf_pkg::PH_P2;
				return 1'b0;
			end
			smf_pkg::PH_P2: begin
				emit_result(smf_pkg::KIND_CHANNEL, held_param, b, 8'h00, 1'b0, 1'b0);
				return 1'b1;
			end
			smf_pkg::PH_MTYPE: begin
				held_meta = b;
				vlq_acc   = '0;
				vlq_count = '0;
				pstate    = smf_pkg::PH_MLEN;
				return 1'b0;
			end
			smf_pkg::PH_MLEN, smf_pkg::PH_SLEN: begin
				if (!vlq_push(b))
					return 1'b0;
				payload_left = vlq_acc;
				emit_result((pstate == smf_pkg::PH_MLEN) ? smf_pkg::KIND_META :
					smf_pkg::KIND_SYSEX, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
				if (vlq_acc == 28'h0)
					return 1'b1;
				pstate = smf_pkg::PH_DATA;
				return 1'b0;
			end
			smf_pkg::PH_DATA: begin
				payload_left = payload_left - 28'd1;
				last = (payload_left == 28'h0);
				emit_result(smf_pkg::KIND_PAYLOAD, 8'h00, 8'h00, b, last,
					last && event_status == smf_pkg::SYSEX_START &&
					b != smf_pkg::SYSEX_END);
				return last;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void track_parse_step(logic op, logic [7:0] b, logic eod,
		logic [15:0] trk);
		bit done;
		done = 1'b0;
		if (op == smf_pkg::OP_BEGIN) begin
			track_idx      = trk;
			tick_sum       = '0;
			last_status    = '0;
			last_status_ok = 1'b0;
			event_status   = '0;
			held_param     = '0;
			held_meta      = '0;
			payload_left   = '0;
			vlq_acc        = '0;
			vlq_count      = '0;
			pstate         = smf_pkg::PH_DELTA;
			return;
		end
		case (pstate)
			smf_pkg::PH_IDLE, smf_pkg::PH_DONE: return;
			smf_pkg::PH_DELTA: begin
				if (vlq_push(b)) begin
					tick_sum = tick_sum + {4'h0, vlq_acc};
					pstate   = smf_pkg::PH_STATUS;
				end
			end
			smf_pkg::PH_STATUS: begin
				if (b >= smf_pkg::STATUS_MIN) begin
					event_status   = b;
					last_status    = b;
					last_status_ok = 1'b1;
					open_event();
				end else if (!last_status_ok) begin
					emit_result(smf_pkg::KIND_NO_RUNNING, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
					pstate = smf_pkg::PH_DONE;
					return;
				end else begin
					event_status = last_status;
					open_event();
					done = parse_body(b);
				end
			end
			default: done = parse_body(b);
		endcase
		if (done) begin
			if (event_status == smf_pkg::META_STATUS && held_meta == smf_pkg::END_OF_TRACK) begin
				emit_result(smf_pkg::KIND_END_TRACK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
				pstate = smf_pkg::PH_DONE;
			end else if (eod) begin
				emit_result(smf_pkg::KIND_END_DATA, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
				pstate = smf_pkg::PH_DONE;
			end else begin
				event_status = '0;
				vlq_acc      = '0;
				vlq_count    = '0;
				pstate       = smf_pkg::PH_DELTA;
			end
		end else if (eod) begin
			emit_result(smf_pkg::KIND_TRUNCATED, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
			pstate = smf_pkg::PH_DONE;
		end
	endfunction

	// big-endian 7-bit groups, continuation on all but the last unless forced
	function automatic void add_vlq(logic [27:0] v, int n, bit cont_last);
		logic [7:0] b;
		for (int i = n - 1; i >= 0; i--) begin
			b = {1'b0, v[7*i +: 7]};
			if (i > 0 || cont_last)
				b[7] = 1'b1;
			add_byte(b);
		end
	endfunction

	function automatic void add_delta(bit heavy);
		int n;
		n = heavy ? 4 : (($urandom_range(99) < 60) ? 1 : $urandom_range(2, 4));
		add_vlq(28'($urandom), n, (n == 4) && ($urandom_range(4) == 0));
	endfunction

	function automatic void add_event();
		bit         running;
		logic [7:0] st;
		logic [7:0] mt;
		logic [7:0] pb;
		int         len;
		int         nlen;
		running = gen_has && ($urandom_range(3) == 0);
		if (running) begin
			st = gen_status;
		end else begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: st = smf_pkg::STATUS_MIN + 8'($urandom_range(8'h6F));
				6, 7: st = smf_pkg::META_STATUS;
				8: st = smf_pkg::SYSEX_START;
				default: st = $urandom_range(1) ? smf_pkg::SYSEX_END :
					8'($urandom_range(8'hF1, 8'hFE));
			endcase
			add_byte(st);
			gen_status = st;
			gen_has    = 1'b1;
		end
		if (st < smf_pkg::SYSEX_START) begin
			add_byte(running ? 8'($urandom_range(8'h7F)) : 8'($urandom));
			if (st[7:4] != smf_pkg::HI_PROGRAM && st[7:4] != smf_pkg::HI_PRESSURE)
				add_byte(8'($urandom));
		end else begin
			if (st == smf_pkg::META_STATUS) begin
				mt = running ? 8'($urandom_range(8'h7F)) : 8'($urandom);
				if (mt == smf_pkg::END_OF_TRACK)
					mt = 8'h01;
				add_byte(mt);
			end
			len  = $urandom_range(4);
			nlen = ($urandom_range(4) == 0) ? $urandom_range(1, 4) : 1;
			if (running && st != smf_pkg::META_STATUS)
				nlen = 1;
			add_vlq(28'(len), nlen, 1'b0);
			for (int i = 0; i < len; i++) begin
				pb = 8'($urandom);
				if (st == smf_pkg::SYSEX_START && i == len - 1 && $urandom_range(1))
					pb = smf_pkg::SYSEX_END;
				add_byte(pb);
			end
		end
	endfunction

	function automatic void build_track(int n_events, bit heavy);
		int len;
		track_q.delete();
		gen_has = 1'b0;
		repeat (n_events) begin
			add_delta(heavy);
			add_event();
		end
		if ($urandom_range(3) != 0) begin
			add_delta(heavy);
			if (!(gen_has && gen_status == smf_pkg::META_STATUS && $urandom_range(2) == 0))
				add_byte(smf_pkg::META_STATUS);
			add_byte(smf_pkg::END_OF_TRACK);
			len = $urandom_range(1);
			add_vlq(28'(len), 1, 1'b0);
			if (len != 0)
				add_byte(8'($urandom));
		end
	endfunction

	task automatic send_byte(logic op, logic [7:0] b, logic eod, logic [15:0] trk);
		while (!no_gaps && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {trk, b};
		s_tlast  <= eod;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (op == smf_pkg::OP_BEGIN || !(pstate inside {smf_pkg::PH_IDLE, smf_pkg::PH_DONE}))
			items_sent++;
		track_parse_step(op, b, eod, trk);
	endtask

	// sends track_q, tlast on index cut, stopping there
	task automatic send_stream(int cut);
		for (int i = 0; i < track_q.size(); i++) begin
			send_byte(smf_pkg::OP_DATA, track_q[i], i == cut, 16'($urandom));
			if (i == cut)
				break;
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (expected_events.size() != 0);
	endtask

	task automatic send_track(bit heavy);
		int cut;
		build_track(heavy ? $urandom_range(20, 35) : $urandom_range(1, 12), heavy);
		send_byte(smf_pkg::OP_BEGIN, 8'($urandom), 1'($urandom_range(1)), 16'($urandom));
		if ($urandom_range(99) < 15)
			cut = $urandom_range(track_q.size() - 1);
		else
			cut = $urandom_range(1) ? track_q.size() - 1 : -1;
		send_stream(cut);
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 3))
				send_byte(smf_pkg::OP_DATA, 8'($urandom), 1'($urandom_range(1)),
					16'($urandom));
		end
	endtask

	task automatic test_directed_cases();
		// byte before any begin is dropped
		send_byte(smf_pkg::OP_DATA, 8'hAA, 1'b0, 16'h5555);
		// running status with no prior event, then data after the stop
		send_byte(smf_pkg::OP_BEGIN, 8'h00, 1'b0, 16'hFFFF);
		track_q = '{8'h00, 8'h40, 8'h90};
		send_stream(-1);
		// longest delta, program change, running status, max length cut short
		send_byte(smf_pkg::OP_BEGIN, 8'hFF, 1'b1, 16'h0000);
		track_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hC5, 8'h7F, 8'h00, 8'h20,
			8'h00, 8'hFF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00};
		send_stream(track_q.size() - 1);
		// last byte completes an event
		send_byte(smf_pkg::OP_BEGIN, 8'h00, 1'b0, 16'h8000);
		track_q = '{8'h00, 8'hE3, 8'h00, 8'hFF};
		send_stream(3);
		// sysex left open, then end of track together with end of data
		send_byte(smf_pkg::OP_BEGIN, 8'h00, 1'b0, 16'h1234);
		track_q = '{8'h00, 8'hF0, 8'h02, 8'h11, 8'h22, 8'h00, 8'hFF, 8'h2F, 8'h00};
		send_stream(8);
		wait_drained();
	endtask

	task automatic test_random_tracks();
		while (items_sent < 900) begin
			send_track($urandom_range(9) == 0);
			if ($urandom_range(9) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	task automatic test_back_to_back();
		no_gaps = 1'b1;
		while (items_sent < 1100)
			send_track($urandom_range(7) == 0);
		wait_drained();
		no_gaps = 1'b0;
	endtask

	task automatic test_noise();
		repeat (4) begin
			send_byte(smf_pkg::OP_BEGIN, 8'($urandom), 1'b0, 16'($urandom));
			repeat (40) begin
				send_byte(($urandom_range(99) < 5) ? smf_pkg::OP_BEGIN : smf_pkg::OP_DATA,
					8'($urandom), $urandom_range(99) < 8, 16'($urandom));
			end
		end
		wait_drained();
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		smf_pkg::res_t got;
		smf_pkg::res_t want;
		if (m_tvalid && m_tready) begin
			got.abs_tick        = m_tdata[31:0];
			got.status_code     = m_tdata[39:32];
			got.channel         = m_tdata[43:40];
			got.param_one       = m_tdata[51:44];
			got.param_two       = m_tdata[59:52];
			got.meta_type       = m_tdata[67:60];
			got.payload_length  = m_tdata[95:68];
			got.payload_value   = m_tdata[103:96];
			got.track_id        = m_tdata[119:104];
			got.kind            = smf_pkg::kind_t'(m_tuser[2:0]);
			got.sysex_continues = m_tuser[3];
			got.payload_last    = m_tlast;
			if (expected_events.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction, expected none, actual %0h %0h", $time,
					m_tuser, m_tdata);
			end else begin
				want = expected_events.pop_front();
				check_field("kind", 32'(want.kind), 32'(got.kind));
				check_field("abs_tick", want.abs_tick, got.abs_tick);
				check_field("status_code", 32'(want.status_code), 32'(got.status_code));
				check_field("channel", 32'(want.channel), 32'(got.channel));
				check_field("param_one", 32'(want.param_one), 32'(got.param_one));
				check_field("param_two", 32'(want.param_two), 32'(got.param_two));
				check_field("meta_type", 32'(want.meta_type), 32'(got.meta_type));
				check_field("payload_length", 32'(want.payload_length),
					32'(got.payload_length));
				check_field("payload_value", 32'(want.payload_value), 32'(got.payload_value));
				check_field("payload_last", 32'(want.payload_last), 32'(got.payload_last));
				check_field("sysex_continues", 32'(want.sysex_continues),
					32'(got.sysex_continues));
				check_field("track_id", 32'(want.track_id), 32'(got.track_id));
			end
		end
		m_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 34);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("smf_track_event_parser_top_test failed");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_tracks();
		test_back_to_back();
		test_noise();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && expected_events.size() == 0) begin
			$display("smf_track_event_parser_top_test passed");
		end else begin
			$display("smf_track_event_parser_top_test failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/smf_pkg.sv
hdl/smf_parse.sv
hdl/smf_out_stage.sv
hdl/smf_track_event_parser_top.sv
tb/sv/smf_track_event_parser_top_test.sv
